### design/kwm_pkg.sv
`timescale 1ns / 1ps
package kwm_pkg;

  // Default number of lane slots.
  localparam int LANES_DEF = 8;

  // Register indexes of the configuration port.
  localparam int REG_ACTIVE_LANES = 0;

  // Value of active_lanes after reset.
  localparam logic [3:0] ACTIVE_RESET = 4'd8;

  // One record as delivered on a lane.
  typedef struct packed {
    logic signed [63:0] coeff0;
    logic signed [63:0] coeff1;
    logic signed [63:0] coeff2;
    logic signed [63:0] coeff3;
    logic signed [63:0] coeff4;
    logic signed [63:0] point;
  } rec_t;

  // One head slot as held in the record memory.
  typedef struct packed {
    logic signed [63:0] key;
    rec_t               rec;
  } entry_t;

endpackage

### design/kwm_if.sv
`timescale 1ns / 1ps
// Request channel carrying one lane record.
interface kwm_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         lane;
  logic signed [63:0] coeff0;
  logic signed [63:0] coeff1;
  logic signed [63:0] coeff2;
  logic signed [63:0] coeff3;
  logic signed [63:0] coeff4;
  logic signed [63:0] point;
  logic               lane_last;
  modport source (output valid, lane, coeff0, coeff1, coeff2, coeff3, coeff4, point,
                  lane_last, input ready);
  modport sink (input valid, lane, coeff0, coeff1, coeff2, coeff3, coeff4, point,
                lane_last, output ready);
endinterface

// Result channel carrying one emitted record.
interface kwm_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         out_lane;
  logic signed [63:0] out_coeff0;
  logic signed [63:0] out_coeff1;
  logic signed [63:0] out_coeff2;
  logic signed [63:0] out_coeff3;
  logic signed [63:0] out_coeff4;
  logic signed [63:0] out_point;
  logic signed [63:0] out_key;
  logic               run_last;
  modport source (output valid, out_lane, out_coeff0, out_coeff1, out_coeff2, out_coeff3,
                  out_coeff4, out_point, out_key, run_last, input ready);
  modport sink (input valid, out_lane, out_coeff0, out_coeff1, out_coeff2, out_coeff3,
                out_coeff4, out_point, out_key, run_last, output ready);
endinterface

### design/kwm_ram.sv
`timescale 1ns / 1ps
module kwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port, registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/kwm_mul.sv
`timescale 1ns / 1ps
module kwm_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] p_o
);

  logic [63:0] a_q, b_q, acc_q, acc_d;
  logic [1:0]  step_q, step_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [31:0] opa, opb;
  logic [63:0] prod;

  // Low 64 bits of the product from three 32x32 partial products, one per cycle.
  always_comb begin
    case (step_q)
      2'd0:    begin opa = a_q[31:0];  opb = b_q[31:0];  end
      2'd1:    begin opa = a_q[63:32]; opb = b_q[31:0];  end
      2'd2:    begin opa = a_q[31:0];  opb = b_q[63:32]; end
      default: begin opa = a_q[31:0];  opb = b_q[31:0];  end
    endcase
    prod = {32'b0, opa} * {32'b0, opb};
  end

  always_comb begin
    acc_d  = acc_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (busy_q) begin
      if (step_q == 2'd0) begin
        acc_d = prod;
      end else begin
        acc_d = acc_q + {prod[31:0], 32'b0};
      end
      step_d = step_q + 2'd1;
      if (step_q == 2'd2) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    if (start_i) begin
      busy_d = 1'b1;
      step_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= 2'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

### design/kway_merge_polynomial_key_core.sv
`timescale 1ns / 1ps
// K-way merge of sorted lanes ordered by the key a0+a1*x+a2*x^2+a3*x^3+a4*x^4 taken
// modulo 2^64 and compared as a signed value; ties go to the lowest lane. The block
// takes one request at a time. A request that fills a head slot has its key computed
// (four Horner steps on one shared multiplier, each a start, three 32x32 partial
// products and a done) and is written into the record memory; a dropped request
// skips this. Then a check state follows, and for each emitted record a scan of the
// record memory, one lane per cycle over the n active lanes followed by the read
// latency and the last compare, and an emit state that waits while the output
// register holds a result not yet taken. Results wait in that output register, so
// the next request is taken while a result is still pending.
module kway_merge_polynomial_key_core #(
  parameter int LANES = kwm_pkg::LANES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kwm_in_if.sink      req_i,
  kwm_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import kwm_pkg::*;

  localparam int LW = $clog2(LANES);
  localparam int NW = ($clog2(LANES + 1) > 4) ? $clog2(LANES + 1) : 4;
  localparam int EW = $bits(entry_t);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_KEY   = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [3:0]       act_q;
  logic [NW-1:0]    n_lanes, act_ext, lane_ext, best_ext;
  logic [LANES-1:0] act_mask, valid_q, valid_d, final_q, final_d, fin_q, fin_d;
  logic [LW-1:0]    lane_idx;
  logic             store;

  // Configuration register; pready is always high.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {28'b0, act_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= ACTIVE_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'(REG_ACTIVE_LANES))) begin
      act_q <= pwdata[3:0];
    end
  end

  // Active lane count, clamped to the range 1 to LANES.
  always_comb begin
    act_ext = {{(NW-4){1'b0}}, act_q};
    if (act_ext == '0) begin
      n_lanes = NW'(1);
    end else if (act_ext > NW'(LANES)) begin
      n_lanes = NW'(LANES);
    end else begin
      n_lanes = act_ext;
    end
    for (int i = 0; i < LANES; i++) begin
      act_mask[i] = (NW'(i) < n_lanes);
    end
  end

  assign lane_ext = {{(NW-3){1'b0}}, req_i.lane};
  assign lane_idx = lane_ext[LW-1:0];
  assign store    = (lane_ext < n_lanes) && !valid_q[lane_idx] && !fin_q[lane_idx];

  // Record being keyed.
  rec_t          rec_q;
  logic          last_q;
  logic [LW-1:0] wlane_q;
  logic [63:0]   h_q, h_d, coef;
  logic [1:0]    kidx_q, kidx_d;
  logic          mstart_q, mstart_d, mdone;
  logic [63:0]   mp;

  kwm_mul u_mul (
    .clk_i,
    .rst_ni,
    .start_i (mstart_q),
    .a_i     (h_q),
    .b_i     (rec_q.point),
    .done_o  (mdone),
    .p_o     (mp)
  );

  // Horner coefficient for the current step.
  always_comb begin
    case (kidx_q)
      2'd0:    coef = rec_q.coeff3;
      2'd1:    coef = rec_q.coeff2;
      2'd2:    coef = rec_q.coeff1;
      default: coef = rec_q.coeff0;
    endcase
  end

  // Record memory and scan.
  logic          we;
  logic [LW-1:0] raddr;
  logic [EW-1:0] rdata;
  entry_t        rd_ent, wr_ent, best_q, best_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [LW-1:0] rd_idx_q, best_lane_q, best_lane_d;
  logic          rd_v_q, rd_v_d, found_q, found_d;

  assign wr_ent.key = h_d;
  assign wr_ent.rec = rec_q;
  assign raddr      = cnt_q[LW-1:0];
  assign rd_ent     = entry_t'(rdata);

  kwm_ram #(.WIDTH(EW), .DEPTH(LANES)) u_ram (
    .clk_i,
    .we_i    (we),
    .waddr_i (wlane_q),
    .wdata_i (wr_ent),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Output register.
  logic       out_v_q, out_v_d, out_load, out_last_d;
  entry_t     out_ent_q;
  logic [2:0] out_lane_q;
  logic       out_last_q;
  logic [LANES-1:0] fin_new;

  assign best_ext = {{(NW-LW){1'b0}}, best_lane_q};

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    valid_d     = valid_q;
    final_d     = final_q;
    fin_d       = fin_q;
    h_d         = h_q;
    kidx_d      = kidx_q;
    mstart_d    = 1'b0;
    we          = 1'b0;
    cnt_d       = cnt_q;
    rd_v_d      = 1'b0;
    found_d     = found_q;
    best_d      = best_q;
    best_lane_d = best_lane_q;
    out_load    = 1'b0;
    out_last_d  = 1'b0;
    fin_new     = fin_q;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (store) begin
            h_d      = req_i.coeff4;
            kidx_d   = 2'd0;
            mstart_d = 1'b1;
            state_d  = ST_KEY;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_KEY: begin
        if (mdone) begin
          h_d = mp + coef;
          if (kidx_q == 2'd3) begin
            we               = 1'b1;
            valid_d[wlane_q] = 1'b1;
            final_d[wlane_q] = last_q;
            state_d          = ST_CHECK;
          end else begin
            kidx_d   = kidx_q + 2'd1;
            mstart_d = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (&(fin_q | ~act_mask)) begin
          valid_d = '0;
          final_d = '0;
          fin_d   = '0;
          state_d = ST_IDLE;
        end else if (&(valid_q | fin_q | ~act_mask)) begin
          cnt_d   = '0;
          found_d = 1'b0;
          state_d = ST_SCAN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (cnt_q < n_lanes) begin
          rd_v_d = 1'b1;
          cnt_d  = cnt_q + NW'(1);
        end
        if (rd_v_q && !fin_q[rd_idx_q]) begin
          if (!found_q || ($signed(rd_ent.key) < $signed(best_q.key))) begin
            best_d      = rd_ent;
            best_lane_d = rd_idx_q;
            found_d     = 1'b1;
          end
        end
        if (!rd_v_q && (cnt_q >= n_lanes)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_v_q || res_o.ready) begin
          out_load             = 1'b1;
          valid_d[best_lane_q] = 1'b0;
          state_d              = ST_CHECK;
          if (final_q[best_lane_q]) begin
            final_d[best_lane_q] = 1'b0;
            fin_new[best_lane_q] = 1'b1;
            fin_d                = fin_new;
            if (&(fin_new | ~act_mask)) begin
              out_last_d = 1'b1;
              valid_d    = '0;
              final_d    = '0;
              fin_d      = '0;
              state_d    = ST_IDLE;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign req_i.ready = (state_q == ST_IDLE);
  assign out_v_d     = out_load || (out_v_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      final_q  <= '0;
      fin_q    <= '0;
      mstart_q <= 1'b0;
      rd_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      final_q  <= final_d;
      fin_q    <= fin_d;
      mstart_q <= mstart_d;
      rd_v_q   <= rd_v_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    h_q         <= h_d;
    kidx_q      <= kidx_d;
    cnt_q       <= cnt_d;
    rd_idx_q    <= raddr;
    found_q     <= found_d;
    best_q      <= best_d;
    best_lane_q <= best_lane_d;
    if (req_i.valid && req_i.ready) begin
      rec_q.coeff0 <= req_i.coeff0;
      rec_q.coeff1 <= req_i.coeff1;
      rec_q.coeff2 <= req_i.coeff2;
      rec_q.coeff3 <= req_i.coeff3;
      rec_q.coeff4 <= req_i.coeff4;
      rec_q.point  <= req_i.point;
      last_q       <= req_i.lane_last;
      wlane_q      <= lane_idx;
    end
    if (out_load) begin
      out_ent_q  <= best_q;
      out_lane_q <= best_ext[2:0];
      out_last_q <= out_last_d;
    end
  end

  assign res_o.valid      = out_v_q;
  assign res_o.out_lane   = out_lane_q;
  assign res_o.out_coeff0 = out_ent_q.rec.coeff0;
  assign res_o.out_coeff1 = out_ent_q.rec.coeff1;
  assign res_o.out_coeff2 = out_ent_q.rec.coeff2;
  assign res_o.out_coeff3 = out_ent_q.rec.coeff3;
  assign res_o.out_coeff4 = out_ent_q.rec.coeff4;
  assign res_o.out_point  = out_ent_q.rec.point;
  assign res_o.out_key    = out_ent_q.key;
  assign res_o.run_last   = out_last_q;

endmodule

### design/kwm_checker.sv
`timescale 1ns / 1ps
module kwm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_key,
  input logic        run_last,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(run_last))
    else $error("stalled result changed");

  // One request at a time: the block is busy in the cycle after it takes a request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // The register reads back the low four bits that were written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && !paddr[2] |=>
      (paddr[2] || prdata == {28'b0, $past(pwdata[3:0])}))
    else $error("register readback mismatch");

  // The configuration port never waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind kway_merge_polynomial_key_core kwm_checker u_kwm_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (req_i.valid),
  .in_ready  (req_i.ready),
  .out_valid (res_o.valid),
  .out_ready (res_o.ready),
  .out_key   (res_o.out_key),
  .run_last  (res_o.run_last),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata),
  .pready    (pready)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import kwm_pkg::*;

  localparam logic [63:0] KEY_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] KEY_MIN = 64'h8000_0000_0000_0000;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int SETTLE = 200;

  typedef struct {
    logic [2:0]  lane;
    rec_t        rec;
    bit          last;
    bit          chk;
    logic [63:0] key;
  } lane_rec_t;

  typedef struct {
    logic [2:0]  lane;
    rec_t        rec;
    logic [63:0] key;
    bit          run_last;
  } merged_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  kwm_in_if req ();
  kwm_out_if res ();

  kway_merge_polynomial_key_core uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req),
    .res_o  (res),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Predictor state: held heads per lane and the lane count register.
  rec_t        head_rec[8];
  logic [63:0] head_key[8];
  bit          head_full[8];
  bit          head_last[8];
  bit          lane_done[8];
  logic [3:0]  lanes_cfg = ACTIVE_RESET;

  merged_rec_t merged_q[$];
  lane_rec_t   cur_req;
  int          errors = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  bit          stall_go = 1'b0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    errors++;
  endtask

  function automatic logic [63:0] poly_eval(input rec_t r);
    logic [63:0] x2, x3, x4;
    x2 = r.point * r.point;
    x3 = x2 * r.point;
    x4 = x3 * r.point;
    return r.coeff0 + r.coeff1 * r.point + r.coeff2 * x2 + r.coeff3 * x3 + r.coeff4 * x4;
  endfunction

  function automatic int live_lanes();
    if (lanes_cfg == 0) return 1;
    if (lanes_cfg > 8) return 8;
    return int'(lanes_cfg);
  endfunction

  function automatic void clear_lanes();
    for (int i = 0; i < 8; i++) begin
      head_full[i] = 0;
      head_last[i] = 0;
      lane_done[i] = 0;
    end
  endfunction

  // Takes one accepted request and queues every record it lets out.
  function automatic void merge_step(input lane_rec_t r);
    int n, best, count;
    bit all_full, all_done, found;
    merged_rec_t m;
    n = live_lanes();
    count = 0;
    if (r.lane < n && !head_full[r.lane] && !lane_done[r.lane]) begin
      head_rec[r.lane] = r.rec;
      head_key[r.lane] = r.chk ? r.key : poly_eval(r.rec);
      head_last[r.lane] = r.last;
      head_full[r.lane] = 1;
    end
    while (count < 8) begin
      all_full = 1;
      all_done = 1;
      found = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        if (lane_done[i]) continue;
        all_done = 0;
        if (!head_full[i]) begin
          all_full = 0;
          break;
        end
        if (!found || $signed(head_key[i]) < $signed(head_key[best])) begin
          best = i;
          found = 1;
        end
      end
      if (all_done) begin
        clear_lanes();
        break;
      end
      if (!all_full || !found) break;
      m.lane = best[2:0];
      m.rec = head_rec[best];
      m.key = head_key[best];
      m.run_last = 0;
      count++;
      head_full[best] = 0;
      if (head_last[best]) begin
        head_last[best] = 0;
        lane_done[best] = 1;
        all_done = 1;
        for (int i = 0; i < n; i++)
          if (!lane_done[i]) all_done = 0;
        if (all_done) begin
          m.run_last = 1;
          merged_q.insert(merged_q.size(), m);
          clear_lanes();
          break;
        end
      end
      merged_q.insert(merged_q.size(), m);
    end
  endfunction

  // Watch both channels and the register port at every edge.
  always @(posedge clk) begin
    merged_rec_t m;
    lane_rec_t r;
    if (psel && penable && pwrite && pready && paddr == 3'(REG_ACTIVE_LANES * 4))
      lanes_cfg = pwdata[3:0];
    if (req.valid && req.ready) begin
      r = cur_req;
      r.lane = req.lane;
      r.rec = '{req.coeff0, req.coeff1, req.coeff2, req.coeff3, req.coeff4, req.point};
      r.last = req.lane_last;
      merge_step(r);
    end
    if (res.valid && res.ready) begin
      if (merged_q.size() == 0) begin
        report_mismatch("result with nothing pending, key", res.out_key, '0);
      end else begin
        m = merged_q.pop_front();
        if (res.out_lane !== m.lane) report_mismatch("lane", res.out_lane, m.lane);
        if (res.out_coeff0 !== m.rec.coeff0) report_mismatch("a0", res.out_coeff0, m.rec.coeff0);
        if (res.out_coeff1 !== m.rec.coeff1) report_mismatch("a1", res.out_coeff1, m.rec.coeff1);
        if (res.out_coeff2 !== m.rec.coeff2) report_mismatch("a2", res.out_coeff2, m.rec.coeff2);
        if (res.out_coeff3 !== m.rec.coeff3) report_mismatch("a3", res.out_coeff3, m.rec.coeff3);
        if (res.out_coeff4 !== m.rec.coeff4) report_mismatch("a4", res.out_coeff4, m.rec.coeff4);
        if (res.out_point !== m.rec.point) report_mismatch("point", res.out_point, m.rec.point);
        if (res.out_key !== m.key) report_mismatch("key", res.out_key, m.key);
        if (res.run_last !== m.run_last) report_mismatch("run_last", res.run_last, m.run_last);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result side: random back-pressure, one long hold-off on request.
  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_go) begin
        stall_go = 0;
        res.ready <= 1'b0;
        repeat (600) @(posedge clk);
      end else begin
        res.ready <= calm || ($urandom_range(99) >= 20);
      end
    end
  end

  task automatic reg_write(input int idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(idx * 4);
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reg_read(input int idx, output logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= 3'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    val = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Offer one request and hold it until it is taken.
  task automatic send_req(input lane_rec_t r);
    if (!calm && $urandom_range(99) < 20) repeat ($urandom_range(1, 8)) @(posedge clk);
    cur_req <= r;
    req.valid <= 1'b1;
    req.lane <= r.lane;
    req.coeff0 <= r.rec.coeff0;
    req.coeff1 <= r.rec.coeff1;
    req.coeff2 <= r.rec.coeff2;
    req.coeff3 <= r.rec.coeff3;
    req.coeff4 <= r.rec.coeff4;
    req.point <= r.rec.point;
    req.lane_last <= r.last;
    do @(posedge clk); while (!req.ready);
    req.valid <= 1'b0;
  endtask

  // Let all pending results drain, then the block's own latency.
  task automatic settle();
    while (merged_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return KEY_MAX;
      1: return KEY_MIN;
      2: return 64'($signed($urandom_range(16)) - 8);
      3: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic lane_rec_t rand_rec(input int lane, input bit last);
    lane_rec_t r;
    r.lane = 3'(lane);
    r.rec = '{rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word()};
    r.last = last;
    r.chk = 0;
    r.key = '0;
    return r;
  endfunction

  function automatic lane_rec_t row(input int lane, input logic [63:0] a0, a1, a2, a3, a4,
                                    input logic [63:0] x, input bit last, input bit chk,
                                    input logic [63:0] key);
    lane_rec_t r;
    r.lane = 3'(lane);
    r.rec = '{a0, a1, a2, a3, a4, x};
    r.last = last;
    r.chk = chk;
    r.key = key;
    return r;
  endfunction

  lane_rec_t directed[$];

  // Appends one row to the directed table.
  function automatic void add_row(input lane_rec_t r);
    directed.insert(directed.size(), r);
  endfunction

  initial begin
    logic [31:0] rd;
    int remaining[8];
    int eligible[$];
    int sent, phase, n, pick, runs;
    lane_rec_t r;

    req.valid = 1'b0;
    req.lane = '0;
    req.coeff0 = '0;
    req.coeff1 = '0;
    req.coeff2 = '0;
    req.coeff3 = '0;
    req.coeff4 = '0;
    req.point = '0;
    req.lane_last = 1'b0;
    clear_lanes();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register value after reset.
    reg_read(REG_ACTIVE_LANES, rd);
    if (rd[3:0] !== ACTIVE_RESET) report_mismatch("active_lanes after reset", rd, ACTIVE_RESET);
    reg_write(REG_ACTIVE_LANES, 32'd3);

    // Directed requests over three lanes: extremes, ties, wrapping and drops.
    add_row(row(0, KEY_MAX, 0, 0, 0, 0, 0, 0, 1, KEY_MAX));
    add_row(row(1, KEY_MIN, 0, 0, 0, 0, 0, 0, 1, KEY_MIN));
    add_row(row(2, 1, 1, 1, 1, 1, '1, 0, 1, 64'd1));
    add_row(row(1, 1, 0, 0, 0, 0, 0, 0, 1, 64'd1));
    add_row(row(0, 5, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(row(5, 9, 0, 0, 0, 0, 0, 1, 0, 0));
    add_row(row(7, '1, '1, '1, '1, '1, '1, 1, 0, 0));
    add_row(row(1, KEY_MIN, KEY_MIN, KEY_MIN, KEY_MIN, KEY_MIN, KEY_MIN, 0, 0, 0));
    add_row(row(2, -3, 0, 0, 0, 1, 64'h1_0000_0000, 0, 1, -64'sd3));
    add_row(row(1, 0, 1, 0, 0, 0, KEY_MAX, 0, 1, KEY_MAX));
    add_row(row(2, KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX, 0, 0, 0));
    add_row(row(0, 7, 0, 0, 0, 0, 0, 1, 1, 64'd7));
    add_row(row(1, 8, 0, 0, 0, 0, 0, 1, 1, 64'd8));
    add_row(row(2, 8, 0, 0, 0, 0, 0, 1, 1, 64'd8));
    add_row(row(0, 2, 0, 0, 0, 0, 0, 0, 1, 64'd2));
    add_row(row(1, 2, 0, 0, 0, 0, 0, 1, 1, 64'd2));
    add_row(row(2, 2, 0, 0, 0, 0, 0, 1, 1, 64'd2));
    add_row(row(0, 3, 0, 0, 0, 0, 0, 1, 1, 64'd3));
    add_row(row(1, 4, 0, 0, 0, 0, 0, 1, 1, 64'd4));
    add_row(row(2, 4, 0, 0, 0, 0, 0, 1, 1, 64'd4));
    foreach (directed[i]) send_req(directed[i]);
    settle();

    // Lane count change with a head held in a lane that drops out.
    send_req(row(2, 11, 0, 0, 0, 0, 0, 0, 1, 64'd11));
    settle();
    reg_write(REG_ACTIVE_LANES, 32'd2);
    send_req(row(0, 6, 0, 0, 0, 0, 0, 1, 1, 64'd6));
    send_req(row(1, 6, 0, 0, 0, 0, 0, 1, 1, 64'd6));
    settle();

    // Random phases of well-formed runs with some noise.
    sent = 0;
    phase = 0;
    while (sent < 300) begin
      case (phase)
        0: reg_write(REG_ACTIVE_LANES, 32'd1);
        1: reg_write(REG_ACTIVE_LANES, 32'd8);
        2: reg_write(REG_ACTIVE_LANES, 32'd0);
        3: reg_write(REG_ACTIVE_LANES, 32'd15);
        default: reg_write(REG_ACTIVE_LANES, $urandom_range(15));
      endcase
      @(posedge clk);
      calm = (phase == 4);
      if (phase == 1) stall_go = 1;
      n = live_lanes();
      runs = $urandom_range(1, 3);
      for (int k = 0; k < runs; k++) begin
        for (int i = 0; i < 8; i++) remaining[i] = (i < n) ? $urandom_range(1, 4) : 0;
        forever begin
          @(negedge clk);
          eligible.delete();
          for (int i = 0; i < n; i++)
            if (remaining[i] > 0 && !head_full[i] && !lane_done[i])
              eligible.insert(eligible.size(), i);
          if (eligible.size() == 0) break;
          @(posedge clk);
          if ($urandom_range(99) < 10) begin
            r = rand_rec($urandom_range(7), $urandom_range(1));
          end else begin
            pick = eligible[$urandom_range(eligible.size() - 1)];
            remaining[pick]--;
            r = rand_rec(pick, remaining[pick] == 0);
          end
          send_req(r);
          sent++;
        end
        @(posedge clk);
      end
      calm = 0;
      settle();
      phase++;
    end

    settle();
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### kway_merge_polynomial_key_core.f
design/kwm_pkg.sv
design/kwm_if.sv
design/kwm_ram.sv
design/kwm_mul.sv
design/kway_merge_polynomial_key_core.sv
design/kwm_checker.sv
tb/tb_top.sv
